// ===== rtl/ups_pkg.sv =====
// Shared types for the UTF-8 printable sanitizer: the command passed from front to back.
package ups_pkg;

  // Most result bytes that one accepted input byte can release.
  localparam int unsigned SLOTS = 4;

  // One command: the result bytes released by a single input byte.
  typedef struct packed {
    logic [SLOTS-1:0][7:0] bytes;
    logic [SLOTS-1:0]      repl;
    logic [2:0]            count;
    logic                  last;
    logic                  clean;
  } ups_cmd_t;

endpackage

// ===== rtl/ups_front.sv =====
// Front part: takes input bytes, tracks open sequences and builds result commands.
module ups_front
  import ups_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       push,
  input  logic       q_full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       cmd_push,
  output ups_cmd_t   cmd_data
);

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] DEL_CODE   = 8'h7F;
  localparam logic [7:0] REPL_RESET = 8'h3F;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    priority if (b < 8'h80)              len = 3'd1;
    else if ((b & 8'hE0) == 8'hC0)       len = 3'd2;
    else if ((b & 8'hF0) == 8'hE0)       len = 3'd3;
    else if ((b & 8'hF8) == 8'hF0)       len = 3'd4;
    else                                 len = 3'd0;
    return len;
  endfunction

  logic [7:0] repl_r;
  logic [7:0] pend_r [3];
  logic [1:0] pc_r, pc_nxt;
  logic [2:0] need_r, need_nxt;
  logic       clean_r, clean_nxt;

  logic       accept, cont, open, complete;
  logic       seq_done, seq_cut, seq_grow;
  logic [2:0] st_len;
  logic       st_bad, st_emit, st_open;
  logic [1:0] prefix_len;
  logic       prefix_rep;
  logic       tail_valid, tail_rep;
  logic [7:0] tail_byte;
  logic       dirty;
  logic [7:0] p4 [SLOTS];

  assign accept = push && !q_full;

  always_comb begin
    cont     = in_byte[7:6] == 2'b10;
    open     = (need_r != 3'd0) && (pc_r != 2'd0);
    complete = ({1'b0, pc_r} + 3'd1) == need_r;
    seq_done = open && cont && complete;
    seq_cut  = open && cont && !complete && in_last;
    seq_grow = open && cont && !complete && !in_last;

    st_len  = lead_len(in_byte);
    st_bad  = (in_byte < CTRL_LIMIT) || (in_byte == DEL_CODE) || (st_len == 3'd0) ||
              ((st_len > 3'd1) && in_last);
    st_emit = st_bad || (st_len == 3'd1);
    st_open = !st_bad && (st_len > 3'd1);

    // Held bytes come first, either as they are or replaced.
    prefix_len = (open && !seq_grow) ? pc_r : 2'd0;
    prefix_rep = !seq_done;

    priority if (seq_done) begin
      tail_valid = 1'b1;
      tail_byte  = in_byte;
      tail_rep   = 1'b0;
    end else if (seq_cut) begin
      tail_valid = 1'b1;
      tail_byte  = repl_r;
      tail_rep   = 1'b1;
    end else if (seq_grow) begin
      tail_valid = 1'b0;
      tail_byte  = in_byte;
      tail_rep   = 1'b0;
    end else begin
      tail_valid = st_emit;
      tail_byte  = st_bad ? repl_r : in_byte;
      tail_rep   = st_bad;
    end

    p4[0] = pend_r[0];
    p4[1] = pend_r[1];
    p4[2] = pend_r[2];
    p4[3] = 8'h00;

    for (int i = 0; i < SLOTS; i++) begin
      if (3'(i) < {1'b0, prefix_len}) begin
        cmd_data.bytes[i] = prefix_rep ? repl_r : p4[i];
        cmd_data.repl[i]  = prefix_rep;
      end else begin
        cmd_data.bytes[i] = tail_byte;
        cmd_data.repl[i]  = tail_rep;
      end
    end

    dirty = (prefix_rep && (prefix_len != 2'd0)) || (tail_valid && tail_rep);
    cmd_data.count = {1'b0, prefix_len} + {2'b00, tail_valid};
    cmd_data.last  = in_last;
    cmd_data.clean = clean_r && !dirty;
    cmd_push       = accept && (cmd_data.count != 3'd0);

    pc_nxt    = pc_r;
    need_nxt  = need_r;
    clean_nxt = clean_r;
    if (accept) begin
      if (in_last) begin
        pc_nxt    = 2'd0;
        need_nxt  = 3'd0;
        clean_nxt = 1'b1;
      end else begin
        clean_nxt = clean_r && !dirty;
        priority if (seq_grow) begin
          pc_nxt = pc_r + 2'd1;
        end else if (seq_done || !st_open) begin
          pc_nxt   = 2'd0;
          need_nxt = 3'd0;
        end else begin
          pc_nxt   = 2'd1;
          need_nxt = st_len;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r  <= REPL_RESET;
      pc_r    <= 2'd0;
      need_r  <= 3'd0;
      clean_r <= 1'b1;
    end else begin
      if (cfg_wr_en) repl_r <= cfg_wr_data;
      pc_r    <= pc_nxt;
      need_r  <= need_nxt;
      clean_r <= clean_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (seq_grow) begin
        pend_r[pc_r] <= in_byte;
      end else if (!open || !cont) begin
        if (st_open) pend_r[0] <= in_byte;
      end
    end
  end

endmodule

// ===== rtl/ups_queue.sv =====
// Short command queue between front and back, held in flip-flops.
module ups_queue
  import ups_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  ups_cmd_t wr_data,
  input  logic     rd_en,
  output ups_cmd_t rd_data,
  output logic     full,
  output logic     empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ups_cmd_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_wr, do_rd;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= bump(wr_ptr_r);
      if (do_rd) rd_ptr_r <= bump(rd_ptr_r);
      if (do_wr && !do_rd)      cnt_r <= cnt_r + CNT_W'(1);
      else if (do_rd && !do_wr) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== rtl/ups_back.sv =====
// Back part: holds one command and hands out its bytes one request at a time.
module ups_back
  import ups_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  ups_cmd_t   q_data,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_replaced,
  output logic       out_last,
  output logic       out_all_clean
);

  ups_cmd_t   cur_r;
  logic       valid_r;
  logic [1:0] idx_r;
  logic [1:0] last_idx;
  logic       at_end, load;

  assign last_idx      = 2'(cur_r.count - 3'd1);
  assign at_end        = idx_r == last_idx;
  assign load          = !valid_r || (pop && at_end);
  assign q_pop         = load && !q_empty;
  assign empty         = !valid_r;
  assign out_byte      = cur_r.bytes[idx_r];
  assign out_replaced  = cur_r.repl[idx_r];
  assign out_last      = at_end && cur_r.last;
  assign out_all_clean = at_end && cur_r.last && cur_r.clean;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      valid_r <= !q_empty;
      idx_r   <= 2'd0;
    end else if (pop) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) cur_r <= q_data;
  end

endmodule

// ===== rtl/utf8_printable_sanitizer.sv =====
// Top level of the UTF-8 printable sanitizer: front, command queue and back.
//
// The input side behaves as a queue: a byte with its last flag is taken on a
// clock edge where push is high and full is low. The result side is a queue as
// well: while empty is low the oldest result byte, its replaced flag, its last
// flag and the stream's clean flag are shown, and pop takes it.
// Every input byte becomes exactly one result byte, although the bytes of an
// open multi-byte sequence are held back until the sequence completes or breaks,
// when up to four results are released by a single request. The front writes one
// command into a queue of QUEUE_DEPTH entries for each byte that releases results,
// and the back hands out their bytes. A byte that releases results right away is
// registered in the queue and then in the back before it shows. Sustained throughput
// is one byte per cycle on both sides while full is low and pop is high; the queue
// absorbs a burst of up to four released bytes. When the receiver stalls, results
// stay put and the queue fills; full then rises and input stops. Reset (rst_n low at
// a clock edge) empties the queue, closes any open sequence, marks the stream clean
// and sets the replacement byte to '?'. The replacement byte must be written through
// cfg_wr_en and cfg_wr_data only while idle; the block does not enforce it.
module utf8_printable_sanitizer
  import ups_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_replaced,
  output logic       out_last,
  output logic       out_all_clean
);

  ups_cmd_t cmd_data;
  ups_cmd_t q_data;
  logic     cmd_push;
  logic     q_full, q_empty, q_pop;

  // The input side is full exactly when the command queue is.
  assign full = q_full;

  ups_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push       (push),
    .q_full     (q_full),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_data)
  );

  ups_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_data(cmd_data),
    .rd_en  (q_pop),
    .rd_data(q_data),
    .full   (q_full),
    .empty  (q_empty)
  );

  ups_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .out_replaced (out_replaced),
    .out_last     (out_last),
    .out_all_clean(out_all_clean)
  );

endmodule

// ===== rtl/ups_checker.sv =====
// Port-level checks for the UTF-8 printable sanitizer, bound to the top level.
module ups_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_wr_en,
  input logic [7:0] cfg_wr_data,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_replaced,
  input logic       out_last,
  input logic       out_all_clean
);

  // Tracks the replacement byte as written at the port.
  logic [7:0] repl_q;

  always_ff @(posedge clk) begin
    if (!rst_n) repl_q <= 8'h3F;
    else if (cfg_wr_en) repl_q <= cfg_wr_data;
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_clean_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_all_clean |-> out_last)
    else $error("clean flag shown on a result that is not last");

  a_replaced_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_last && out_replaced |-> !out_all_clean)
    else $error("stream reported clean although its last byte was replaced");

  a_replacement_value: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_replaced |-> out_byte == repl_q)
    else $error("replaced byte differs from the replacement register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(out_last))
    else $error("result changed while stalled");

endmodule

bind utf8_printable_sanitizer ups_checker u_ups_checker (.*);
